/* rtl/core/triangle_median_sqrt_top_assert.svh */
// Assertion macros for the triangle median square root block.
// Used by the port checker; needs nothing else.
`ifndef TRIANGLE_MEDIAN_SQRT_TOP_ASSERT_SVH
`define TRIANGLE_MEDIAN_SQRT_TOP_ASSERT_SVH

// same-cycle implication
`define TMS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/tms_pkg.sv */
// Shared types and constants of the triangle median square root block.
// No dependencies; compiled first.
package tms_pkg;

   localparam int MEDIAN_W   = 29;
   localparam int STOP_W     = 16;
   localparam int ITER_W     = 10;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;

   localparam logic [MEDIAN_W-1:0]  MEDIAN_MAX     = '1;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_WIDTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ITER_LIMIT = 1'd1;
   localparam logic [STOP_W-1:0]    STOP_WIDTH_RST = 16'd2;
   localparam logic [ITER_W-1:0]    ITER_LIMIT_RST = 10'd1000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_A,
      ST_SQ_B,
      ST_SQ_C,
      ST_VCHK,
      ST_STEP,
      ST_CROSS,
      ST_HIGH,
      ST_CMP,
      ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      SH_NONE,
      SH_ONE,
      SH_CROSS,
      SH_HIGH
   } mac_shift_type;

   typedef struct packed {
      logic          en;
      logic          clr;
      mac_shift_type shift;
   } mac_op_type;

endpackage

/* rtl/core/tms_req_if.sv */
// Request channel: valid/ready plus the three triangle sides.
// Depends on nothing but its width parameter.
interface tms_req_if #(parameter int SIDE_BITS = 12);
   logic                 valid;
   logic                 ready;
   logic [SIDE_BITS-1:0] side_a;
   logic [SIDE_BITS-1:0] side_b;
   logic [SIDE_BITS-1:0] side_c;

   modport source (output valid, output side_a, output side_b, output side_c, input ready);
   modport sink   (input valid, input side_a, input side_b, input side_c, output ready);
endinterface

/* rtl/core/tms_rsp_if.sv */
// Response channel: valid/ready plus median length and invalid flag.
// Uses tms_pkg for the median width.
interface tms_rsp_if;
   import tms_pkg::*;
   logic                valid;
   logic                ready;
   logic [MEDIAN_W-1:0] median_length;
   logic                invalid;

   modport source (output valid, output median_length, output invalid, input ready);
   modport sink   (input valid, input median_length, input invalid, output ready);
endinterface

/* rtl/core/tms_mac.sv */
// Shared multiply-accumulate unit: one HW x HW product per enabled cycle,
// shifted and added into a 4*HW accumulator. Uses tms_pkg for the op struct.
module tms_mac #(
   parameter int HW = 21
) (
   input  logic                clock,
   input  tms_pkg::mac_op_type op,
   input  logic [HW-1:0]       opa,
   input  logic [HW-1:0]       opb,
   output logic [4*HW-1:0]     acc
);
   import tms_pkg::*;

   localparam int AW = 4 * HW;

   logic [2*HW-1:0] prod;
   logic [AW-1:0]   addend;
   logic [AW-1:0]   acc_ff;
   logic [AW-1:0]   acc_in;

   assign prod = opa * opb;

   always_comb begin
      case (op.shift)
         SH_NONE:  addend = AW'(prod);
         SH_ONE:   addend = AW'(prod) << 1;
         SH_CROSS: addend = AW'(prod) << (HW + 1);  // 2*lo*hi term
         SH_HIGH:  addend = AW'(prod) << (2 * HW);
         default:  addend = AW'(prod);
      endcase
      acc_in = op.clr ? addend : acc_ff + addend;
   end

   always_ff @(posedge clock) begin
      if (op.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

/* rtl/core/triangle_median_sqrt_top.sv */
// Triangle median length by fixed-point bisection square root.
// Uses tms_pkg, tms_req_if, tms_rsp_if and tms_mac.
//
// Request channel (req_if): sides a, b, c, taken when valid and ready are
// both high. Response channel (rsp_if): median_length with FRAC_BITS+1
// fraction bits, and invalid when 2b^2 + 2c^2 - a^2 is negative.
// csr_we/csr_index/csr_wdata write stop_width (index 0) and
// iteration_limit (index 1); write them only while the block is idle.
//
// One request at a time: the squares of a, b and c, a sign check, then
// bisection steps on the shared multiplier (three partial products of
// mid^2, then the compare), a final check and the hand-off to the output
// register. There are at most 42 steps at the defaults; invalid and zero
// cases go from the sign check straight to the hand-off. The next request
// can be taken in the cycle after the hand-off.
// The response sits in an output register; a new request is taken while it
// waits. If the receiver stalls with that register full, the next result
// holds in the block and ready stays low until the register frees.
// Reset (synchronous, active high) empties the output and restores the
// register defaults stop_width = 2 and iteration_limit = 1000.
module triangle_median_sqrt_top #(
   parameter int SIDE_BITS = 12,
   parameter int FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   tms_req_if.sink                          req_if,
   tms_rsp_if.source                        rsp_if,
   input  logic                             csr_we,
   input  logic [tms_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tms_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tms_pkg::*;

   localparam int SQW = 2 * SIDE_BITS;
   localparam int VW  = SQW + 2;
   localparam int MW  = VW + FRAC_BITS;
   localparam int HW  = (MW + 1) / 2;
   localparam int AW  = 4 * HW;
   localparam int DW  = (MW > STOP_W) ? MW : STOP_W;
   localparam int XW  = (MW > MEDIAN_W) ? MW : MEDIAN_W;

   state_type            state_ff, state_in;
   logic [SIDE_BITS-1:0] side_a_ff, side_a_in;
   logic [SIDE_BITS-1:0] side_b_ff, side_b_in;
   logic [SIDE_BITS-1:0] side_c_ff, side_c_in;
   logic [SQW-1:0]       neg_ff, neg_in;
   logic [VW-1:0]        v_ff, v_in;
   logic [MW-1:0]        low_ff, low_in;
   logic [MW-1:0]        high_ff, high_in;
   logic [MW-1:0]        mid_ff, mid_in;
   logic [ITER_W-1:0]    it_ff, it_in;
   logic [MEDIAN_W-1:0]  res_med_ff, res_med_in;
   logic                 res_bad_ff, res_bad_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [MEDIAN_W-1:0]  rsp_med_ff, rsp_med_in;
   logic                 rsp_bad_ff, rsp_bad_in;
   logic [STOP_W-1:0]    stop_w_ff, stop_w_in;
   logic [ITER_W-1:0]    iter_lim_ff, iter_lim_in;

   mac_op_type           mac_op;
   logic [HW-1:0]        mac_a, mac_b;
   logic [AW-1:0]        acc;

   logic [MW:0]          span_sum;
   logic [MW-1:0]        mid_now;
   logic [MW-1:0]        gap;
   logic                 stop_now;
   logic [VW-1:0]        pos;
   logic [VW-1:0]        neg_ext;
   logic [VW-1:0]        diff_v;
   logic [AW-1:0]        target;
   logic                 sq_eq, sq_gt;
   logic [2*HW-1:0]      mid_pad_now, mid_pad_reg;
   logic [MW-1:0]        sat_src;
   logic [MEDIAN_W-1:0]  sat_med;
   logic                 out_free;

   tms_mac #(.HW(HW)) u_mac (
      .clock (clock),
      .op    (mac_op),
      .opa   (mac_a),
      .opb   (mac_b),
      .acc   (acc)
   );

   // bisection arithmetic
   assign span_sum    = (MW + 1)'(low_ff) + (MW + 1)'(high_ff);
   assign mid_now     = span_sum[MW:1];
   assign gap         = high_ff - low_ff;
   assign stop_now    = (it_ff >= iter_lim_ff) || (DW'(gap) < DW'(stop_w_ff));
   assign pos         = acc[VW-1:0];
   assign neg_ext     = VW'(neg_ff);
   assign diff_v      = pos - neg_ext;
   assign target      = AW'(v_ff) << (2 * FRAC_BITS);
   assign sq_eq       = (acc == target);
   assign sq_gt       = (acc > target);
   assign mid_pad_now = (2 * HW)'(mid_now);
   assign mid_pad_reg = (2 * HW)'(mid_ff);
   assign sat_src     = (state_ff == ST_CMP) ? mid_ff : mid_now;
   assign sat_med     = (XW'(sat_src) > XW'(MEDIAN_MAX)) ? MEDIAN_MAX
                                                         : MEDIAN_W'(sat_src);
   assign out_free    = !rsp_valid_ff || rsp_if.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_if.valid) state_in = ST_SQ_A;
         ST_SQ_A:  state_in = ST_SQ_B;
         ST_SQ_B:  state_in = ST_SQ_C;
         ST_SQ_C:  state_in = ST_VCHK;
         ST_VCHK:  state_in = (neg_ext >= pos) ? ST_FIN : ST_STEP;
         ST_STEP:  state_in = stop_now ? ST_FIN : ST_CROSS;
         ST_CROSS: state_in = ST_HIGH;
         ST_HIGH:  state_in = ST_CMP;
         ST_CMP:   state_in = sq_eq ? ST_FIN : ST_STEP;
         ST_FIN:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // unit control
   always_comb begin
      req_if.ready = 1'b0;
      mac_op       = '{en: 1'b0, clr: 1'b0, shift: SH_NONE};
      mac_a        = '0;
      mac_b        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
         end
         ST_SQ_A: begin
            mac_op = '{en: 1'b1, clr: 1'b1, shift: SH_NONE};
            mac_a  = HW'(side_a_ff);
            mac_b  = HW'(side_a_ff);
         end
         ST_SQ_B: begin
            mac_op = '{en: 1'b1, clr: 1'b1, shift: SH_ONE};
            mac_a  = HW'(side_b_ff);
            mac_b  = HW'(side_b_ff);
         end
         ST_SQ_C: begin
            mac_op = '{en: 1'b1, clr: 1'b0, shift: SH_ONE};
            mac_a  = HW'(side_c_ff);
            mac_b  = HW'(side_c_ff);
         end
         ST_STEP: begin
            mac_op = '{en: 1'b1, clr: 1'b1, shift: SH_NONE};
            mac_a  = mid_pad_now[HW-1:0];
            mac_b  = mid_pad_now[HW-1:0];
         end
         ST_CROSS: begin
            mac_op = '{en: 1'b1, clr: 1'b0, shift: SH_CROSS};
            mac_a  = mid_pad_reg[HW-1:0];
            mac_b  = mid_pad_reg[2*HW-1:HW];
         end
         ST_HIGH: begin
            mac_op = '{en: 1'b1, clr: 1'b0, shift: SH_HIGH};
            mac_a  = mid_pad_reg[2*HW-1:HW];
            mac_b  = mid_pad_reg[2*HW-1:HW];
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      side_a_in    = side_a_ff;
      side_b_in    = side_b_ff;
      side_c_in    = side_c_ff;
      neg_in       = neg_ff;
      v_in         = v_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      mid_in       = mid_ff;
      it_in        = it_ff;
      res_med_in   = res_med_ff;
      res_bad_in   = res_bad_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_med_in   = rsp_med_ff;
      rsp_bad_in   = rsp_bad_ff;
      stop_w_in    = stop_w_ff;
      iter_lim_in  = iter_lim_ff;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               side_a_in = req_if.side_a;
               side_b_in = req_if.side_b;
               side_c_in = req_if.side_c;
            end
         end
         ST_SQ_B: begin
            neg_in = acc[SQW-1:0];
         end
         ST_VCHK: begin
            res_bad_in = (neg_ext > pos);
            res_med_in = '0;
            v_in       = diff_v;
            low_in     = '0;
            high_in    = MW'(diff_v) << FRAC_BITS;
            it_in      = '0;
         end
         ST_STEP: begin
            mid_in = mid_now;
            if (stop_now) begin
               res_med_in = sat_med;
            end
         end
         ST_CMP: begin
            if (sq_eq) begin
               res_med_in = sat_med;
            end else if (sq_gt) begin
               high_in = mid_ff;
            end else begin
               low_in = mid_ff;
            end
            it_in = it_ff + 1'b1;
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_med_in   = res_med_ff;
               rsp_bad_in   = res_bad_ff;
            end
         end
         default: begin
         end
      endcase

      if (csr_we) begin
         case (csr_index)
            CSR_STOP_WIDTH: stop_w_in   = csr_wdata[STOP_W-1:0];
            CSR_ITER_LIMIT: iter_lim_in = csr_wdata[ITER_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         stop_w_ff    <= STOP_WIDTH_RST;
         iter_lim_ff  <= ITER_LIMIT_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         stop_w_ff    <= stop_w_in;
         iter_lim_ff  <= iter_lim_in;
      end
   end

   always_ff @(posedge clock) begin
      side_a_ff  <= side_a_in;
      side_b_ff  <= side_b_in;
      side_c_ff  <= side_c_in;
      neg_ff     <= neg_in;
      v_ff       <= v_in;
      low_ff     <= low_in;
      high_ff    <= high_in;
      mid_ff     <= mid_in;
      it_ff      <= it_in;
      res_med_ff <= res_med_in;
      res_bad_ff <= res_bad_in;
      rsp_med_ff <= rsp_med_in;
      rsp_bad_ff <= rsp_bad_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.median_length = rsp_med_ff;
   assign rsp_if.invalid       = rsp_bad_ff;

endmodule

/* rtl/core/tms_checker.sv */
// Port-level checker for the triangle median square root block, with its bind.
// Uses tms_pkg and the assertion macros header.
`include "triangle_median_sqrt_top_assert.svh"

module tms_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [tms_pkg::MEDIAN_W-1:0] rsp_median_length,
   input logic                         rsp_invalid
);
   import tms_pkg::*;

   `TMS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

   `TMS_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "ready high right after a request")

   `TMS_ASSERT_IMPL(a_invalid_zero, clock, reset, rsp_valid && rsp_invalid, rsp_median_length == '0, "invalid response with nonzero median")

   `TMS_ASSERT_IMPL(a_rsp_from_busy, clock, reset, $rose(rsp_valid), !$past(req_ready), "response appeared without work in progress")

endmodule

bind triangle_median_sqrt_top tms_checker u_tms_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_if.valid),
   .req_ready         (req_if.ready),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_median_length (rsp_if.median_length),
   .rsp_invalid       (rsp_if.invalid)
);
